>>> design/bmrrs_pkg.sv
// ----------------------------------------------------------------------------
// Big-M row range sizer package
// Shared types, constants and helpers for the row range sizer and its
// term decode stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmrrs_pkg;

  // Fixed point format and problem size.
  localparam int unsigned FracBits     = 16;
  localparam int unsigned NumVariables = 4096;
  localparam int unsigned MaxRows      = 65536;
  localparam int unsigned RowCntW      = $clog2(MaxRows);

  // Field widths.
  localparam int unsigned ValW   = 48;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned LimitW = 47;
  localparam int unsigned EpsW   = 16;
  localparam int unsigned SkipW  = 13;
  localparam int unsigned BigMW  = 63;
  localparam int unsigned CfgW   = 47;

  // Saturation limits.
  localparam logic [BigMW-1:0] SatU = {BigMW{1'b1}};
  localparam logic [BigMW-1:0] MOne = BigMW'(1) << FracBits;

  // Reset values of the configuration registers.
  localparam logic [LimitW-1:0] OpenLimitRst = {LimitW{1'b1}};
  localparam logic [EpsW-1:0]   CoefEpsRst   = '0;
  localparam logic [SkipW-1:0]  BlameSkipRst = SkipW'(NumVariables);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgOpenLimit  = 2'd0,
    CfgCoefEps    = 2'd1,
    CfgBlameSkip  = 2'd2
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusUnbounded = 2'd1,
    StatusNonfinite = 2'd2
  } status_e;

  // One input term.
  typedef struct packed {
    logic                   is_constant;
    logic [IdxW-1:0]        variable_index;
    logic signed [ValW-1:0] coefficient;
    logic signed [ValW-1:0] var_lower;
    logic signed [ValW-1:0] var_upper;
    logic                   row_active;
    logic signed [ValW-1:0] rhs;
    logic                   rhs_nonfinite;
    logic                   last_in_row;
    logic                   last_in_constraint;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [BigMW-1:0]   big_m;
    status_e            status;
    logic               blame_valid;
    logic [IdxW-1:0]    blame_index;
    logic [RowCntW-1:0] bad_row;
  } out_item_t;

  // Control bits that travel with a term down the pipeline.
  typedef struct packed {
    logic            add_offset;
    logic            row_end;
    logic            row_active;
    logic            rhs_nonfinite;
    logic            last_c;
    logic            set_unb;
    logic            blame_cand;
    logic [IdxW-1:0] idx;
  } ctl_t;

  // Decoded term: control bits and the two multiplier operands.
  typedef struct packed {
    ctl_t            ctl;
    logic            add_prod;
    logic [ValW-1:0] mag_coef;
    logic [ValW-1:0] mag_bound;
  } dec_t;

  // Magnitude of a signed 48-bit value; the most negative value maps to 2^47.
  function automatic logic [ValW-1:0] mag48(logic signed [ValW-1:0] x);
    logic [ValW-1:0] ux;
    ux = $unsigned(x);
    return x[ValW-1] ? (~ux + ValW'(1)) : ux;
  endfunction

endpackage

`default_nettype wire

>>> design/big_m_row_range_sizer_unit.sv
// ----------------------------------------------------------------------------
// Big-M row range sizer
// Streams the terms of one constraint and gives the big-M constant sized
// from the variable bounds, with status and blame information.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  in       | in_valid_i, in_stall_o, in_item_i        | term in
//  out      | out_valid_o, out_stall_i, out_item_o     | result out
//  cfg      | cfg_we_i, cfg_index_i, cfg_wdata_i       | register write
//
// One term is accepted every cycle while in_stall_o is low. The result of a
// constraint is shown on out_valid_o once its final term has passed decode,
// partial products, product merge, row accumulators, rhs difference, row
// range, and the constraint state with the output register. Reset clears all
// control state at once, but not the payload. A stalled result holds only
// the last stage; the earlier stages keep taking items until they are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module big_m_row_range_sizer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bmrrs_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bmrrs_pkg::out_item_t            out_item_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [bmrrs_pkg::CfgW-1:0]      cfg_wdata_i
);
  import bmrrs_pkg::*;

  localparam int unsigned NumStages = 7;
  localparam logic signed [64:0] SLimPos = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SLimNeg = -SLimPos;

  typedef struct packed {
    ctl_t                   ctl;
    logic signed [ValW-1:0] coef;
    logic signed [ValW-1:0] rhs;
    logic [ValW-1:0]        mag_c;
    logic [ValW-1:0]        mag_b;
    logic                   add_prod;
  } s2_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic signed [ValW-1:0] coef;
    logic signed [ValW-1:0] rhs;
    logic [ValW-1:0]        pp_ll;
    logic [ValW-1:0]        pp_lh;
    logic [ValW-1:0]        pp_hl;
    logic [ValW-1:0]        pp_hh;
    logic                   add_prod;
  } s3_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic signed [ValW-1:0] coef;
    logic signed [ValW-1:0] rhs;
    logic [BigMW-1:0]       prod;
  } s4_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic signed [ValW-1:0] rhs;
    logic [BigMW-1:0]       sum;
    logic signed [63:0]     off;
  } s5_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [BigMW-1:0]   sum;
    logic signed [63:0] diff;
  } s6_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [BigMW-1:0] range;
  } s7_t;

  // Configuration registers.
  logic [LimitW-1:0]      open_limit_q;
  logic signed [ValW-1:0] open_neg_q;
  logic [EpsW-1:0]        coef_eps_q;
  logic [SkipW-1:0]       blame_skip_q;

  // Pipeline valid bits and handshake.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] go;
  logic                 out_free;

  // Pipeline payload.
  in_item_t s1_q;
  dec_t     dec;
  s2_t      s2_q, s2_d;
  s3_t      s3_q, s3_d;
  s4_t      s4_q;
  s4_t      s4_d;
  s5_t      s5_q, s5_d;
  s6_t      s6_q, s6_d;
  s7_t      s7_q, s7_d;

  // Row accumulators.
  logic [BigMW-1:0]   row_sum_q, row_sum_d;
  logic signed [63:0] row_off_q, row_off_d;

  // Constraint state.
  logic [BigMW-1:0]   max_range_q, max_range_d;
  logic               unb_seen_q, unb_seen_d;
  logic               blame_found_q, blame_found_d;
  logic [IdxW-1:0]    blame_var_q, blame_var_d;
  logic               nf_seen_q, nf_seen_d;
  logic [RowCntW-1:0] row_cnt_q, row_cnt_d;
  logic [RowCntW-1:0] nf_row_q, nf_row_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // --------------------------------------------------------------------------
  // Handshake: a stage takes a new item when it is empty or its item moves on.
  // Only a final term is held back by a stalled output.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    go[NumStages-1]  = vld_q[NumStages-1] && (!s7_q.ctl.last_c || out_free);
    rdy[NumStages-1] = !vld_q[NumStages-1] || go[NumStages-1];
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
      go[k]  = vld_q[k] && rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? go[k-1] : vld_q[k];
    end
  end

  assign in_stall_o = !rdy[0];

  // --------------------------------------------------------------------------
  // Stage 1: term classification.
  // --------------------------------------------------------------------------
  bmrrs_term_decode u_decode (
    .item_i       (s1_q),
    .open_limit_i (open_limit_q),
    .open_neg_i   (open_neg_q),
    .coef_eps_i   (coef_eps_q),
    .blame_skip_i (blame_skip_q),
    .dec_o        (dec)
  );

  always_comb begin
    s2_d.ctl      = dec.ctl;
    s2_d.coef     = s1_q.coefficient;
    s2_d.rhs      = s1_q.rhs;
    s2_d.mag_c    = dec.mag_coef;
    s2_d.mag_b    = dec.mag_bound;
    s2_d.add_prod = dec.add_prod;
  end

  // --------------------------------------------------------------------------
  // Stage 2: four 24 by 24 partial products.
  // --------------------------------------------------------------------------
  always_comb begin
    s3_d.ctl      = s2_q.ctl;
    s3_d.coef     = s2_q.coef;
    s3_d.rhs      = s2_q.rhs;
    s3_d.add_prod = s2_q.add_prod;
    s3_d.pp_ll    = ValW'(s2_q.mag_c[23:0])  * ValW'(s2_q.mag_b[23:0]);
    s3_d.pp_lh    = ValW'(s2_q.mag_c[23:0])  * ValW'(s2_q.mag_b[47:24]);
    s3_d.pp_hl    = ValW'(s2_q.mag_c[47:24]) * ValW'(s2_q.mag_b[23:0]);
    s3_d.pp_hh    = ValW'(s2_q.mag_c[47:24]) * ValW'(s2_q.mag_b[47:24]);
  end

  // --------------------------------------------------------------------------
  // Stage 3: merge partial products, drop fraction bits, saturate; zero if not added.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [48:0] mid;
    logic [95:0] full;
    logic [95:0] shifted;
    mid     = {1'b0, s3_q.pp_lh} + {1'b0, s3_q.pp_hl};
    full    = 96'(s3_q.pp_ll) + (96'(mid) << 24) + {s3_q.pp_hh, 48'b0};
    shifted = full >> FracBits;
    s4_d.ctl  = s3_q.ctl;
    s4_d.coef = s3_q.coef;
    s4_d.rhs  = s3_q.rhs;
    if (!s3_q.add_prod) begin
      s4_d.prod = '0;
    end else if (|shifted[95:BigMW]) begin
      s4_d.prod = SatU;
    end else begin
      s4_d.prod = shifted[BigMW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: row sum and row offset accumulation, cleared at row end.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [BigMW:0]     sum_raw;
    logic [BigMW-1:0]   sum_new;
    logic signed [64:0] off_raw;
    logic signed [63:0] off_new;
    sum_raw = {1'b0, row_sum_q} + {1'b0, s4_q.prod};
    sum_new = sum_raw[BigMW] ? SatU : sum_raw[BigMW-1:0];
    off_raw = $signed({row_off_q[63], row_off_q})
            + $signed({{17{s4_q.coef[ValW-1]}}, s4_q.coef});
    if (!s4_q.ctl.add_offset) begin
      off_new = row_off_q;
    end else if (off_raw > SLimPos) begin
      off_new = SLimPos[63:0];
    end else if (off_raw < SLimNeg) begin
      off_new = SLimNeg[63:0];
    end else begin
      off_new = off_raw[63:0];
    end
    s5_d.ctl = s4_q.ctl;
    s5_d.rhs = s4_q.rhs;
    s5_d.sum = sum_new;
    s5_d.off = off_new;
    row_sum_d = row_sum_q;
    row_off_d = row_off_q;
    if (go[3]) begin
      row_sum_d = s4_q.ctl.row_end ? '0 : sum_new;
      row_off_d = s4_q.ctl.row_end ? '0 : off_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: rhs minus offset, saturated.
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [64:0] diff_raw;
    diff_raw = $signed({{17{s5_q.rhs[ValW-1]}}, s5_q.rhs})
             - $signed({s5_q.off[63], s5_q.off});
    s6_d.ctl = s5_q.ctl;
    s6_d.sum = s5_q.sum;
    if (diff_raw > SLimPos) begin
      s6_d.diff = SLimPos[63:0];
    end else if (diff_raw < SLimNeg) begin
      s6_d.diff = SLimNeg[63:0];
    end else begin
      s6_d.diff = diff_raw[63:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: row range = |diff| + row sum, saturated.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [64:0] add_pos;
    logic [64:0] add_neg;
    logic [64:0] range_raw;
    add_pos   = {2'b0, s6_q.sum} + {s6_q.diff[63], s6_q.diff};
    add_neg   = {2'b0, s6_q.sum} - {s6_q.diff[63], s6_q.diff};
    range_raw = s6_q.diff[63] ? add_neg : add_pos;
    s7_d.ctl   = s6_q.ctl;
    s7_d.range = (|range_raw[64:BigMW]) ? SatU : range_raw[BigMW-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 7: constraint state, result forming and clearing.
  // --------------------------------------------------------------------------
  always_comb begin
    logic               bf_n;
    logic [IdxW-1:0]    bv_n;
    logic               unb_n;
    logic               nf_n;
    logic [RowCntW-1:0] nfr_n;
    logic [BigMW-1:0]   max_n;
    logic [RowCntW-1:0] cnt_n;
    logic               row_take;
    logic [BigMW:0]     m_raw;

    // Blame keeps the first open variable in stream order.
    bf_n  = blame_found_q || s7_q.ctl.blame_cand;
    bv_n  = blame_found_q ? blame_var_q
          : (s7_q.ctl.blame_cand ? s7_q.ctl.idx : blame_var_q);
    unb_n = unb_seen_q || s7_q.ctl.set_unb;

    // Row end of an active row: record a non-finite bound or the range.
    row_take = s7_q.ctl.row_end && s7_q.ctl.row_active;
    nf_n     = nf_seen_q;
    nfr_n    = nf_row_q;
    max_n    = max_range_q;
    if (row_take && s7_q.ctl.rhs_nonfinite) begin
      nf_n = 1'b1;
      if (!nf_seen_q) begin
        nfr_n = row_cnt_q;
      end
    end else if (row_take && (s7_q.range > max_range_q)) begin
      max_n = s7_q.range;
    end
    cnt_n = s7_q.ctl.row_end ? row_cnt_q + RowCntW'(1) : row_cnt_q;

    // Result: non-finite bound wins over an unbounded contributor.
    m_raw      = {1'b0, max_n} + {1'b0, MOne};
    out_item_d = '0;
    if (nf_n) begin
      out_item_d.status  = StatusNonfinite;
      out_item_d.bad_row = nfr_n;
    end else if (unb_n) begin
      out_item_d.status      = StatusUnbounded;
      out_item_d.blame_valid = bf_n;
      out_item_d.blame_index = bf_n ? bv_n : '0;
    end else begin
      out_item_d.status = StatusOk;
      out_item_d.big_m  = m_raw[BigMW] ? SatU : m_raw[BigMW-1:0];
    end

    // State update; everything clears after a constraint's result.
    max_range_d   = max_range_q;
    unb_seen_d    = unb_seen_q;
    blame_found_d = blame_found_q;
    blame_var_d   = blame_var_q;
    nf_seen_d     = nf_seen_q;
    row_cnt_d     = row_cnt_q;
    nf_row_d      = nf_row_q;
    if (go[NumStages-1]) begin
      if (s7_q.ctl.last_c) begin
        max_range_d   = '0;
        unb_seen_d    = 1'b0;
        blame_found_d = 1'b0;
        blame_var_d   = '0;
        nf_seen_d     = 1'b0;
        row_cnt_d     = '0;
        nf_row_d      = '0;
      end else begin
        max_range_d   = max_n;
        unb_seen_d    = unb_n;
        blame_found_d = bf_n;
        blame_var_d   = bv_n;
        nf_seen_d     = nf_n;
        row_cnt_d     = cnt_n;
        nf_row_d      = nfr_n;
      end
    end

    // Output register loads a result and drops it once taken.
    if (go[NumStages-1] && s7_q.ctl.last_c) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Control state, accumulators and configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      out_valid_q   <= 1'b0;
      row_sum_q     <= '0;
      row_off_q     <= '0;
      max_range_q   <= '0;
      unb_seen_q    <= 1'b0;
      blame_found_q <= 1'b0;
      blame_var_q   <= '0;
      nf_seen_q     <= 1'b0;
      row_cnt_q     <= '0;
      nf_row_q      <= '0;
      open_limit_q  <= OpenLimitRst;
      open_neg_q    <= -$signed({1'b0, OpenLimitRst});
      coef_eps_q    <= CoefEpsRst;
      blame_skip_q  <= BlameSkipRst;
    end else begin
      vld_q         <= vld_d;
      out_valid_q   <= out_valid_d;
      row_sum_q     <= row_sum_d;
      row_off_q     <= row_off_d;
      max_range_q   <= max_range_d;
      unb_seen_q    <= unb_seen_d;
      blame_found_q <= blame_found_d;
      blame_var_q   <= blame_var_d;
      nf_seen_q     <= nf_seen_d;
      row_cnt_q     <= row_cnt_d;
      nf_row_q      <= nf_row_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgOpenLimit: begin
            open_limit_q <= cfg_wdata_i[LimitW-1:0];
            open_neg_q   <= -$signed({1'b0, cfg_wdata_i[LimitW-1:0]});
          end
          CfgCoefEps: begin
            coef_eps_q <= cfg_wdata_i[EpsW-1:0];
          end
          CfgBlameSkip: begin
            blame_skip_q <= cfg_wdata_i[SkipW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline payload registers; a stage loads whenever it can take an item.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q <= in_item_i;
    end
    if (rdy[1]) begin
      s2_q <= s2_d;
    end
    if (rdy[2]) begin
      s3_q <= s3_d;
    end
    if (rdy[3]) begin
      s4_q <= s4_d;
    end
    if (rdy[4]) begin
      s5_q <= s5_d;
    end
    if (rdy[5]) begin
      s6_q <= s6_d;
    end
    if (rdy[6]) begin
      s7_q <= s7_d;
    end
    if (go[NumStages-1] && s7_q.ctl.last_c) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

`default_nettype wire

>>> design/bmrrs_term_decode.sv
// ----------------------------------------------------------------------------
// Big-M row range sizer term decode
// Classifies one term: open bound test, coefficient threshold, blame
// candidacy, and the magnitudes that feed the product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmrrs_term_decode (
  input  bmrrs_pkg::in_item_t                      item_i,
  input  logic [bmrrs_pkg::LimitW-1:0]             open_limit_i,
  input  logic signed [bmrrs_pkg::ValW-1:0]        open_neg_i,
  input  logic [bmrrs_pkg::EpsW-1:0]               coef_eps_i,
  input  logic [bmrrs_pkg::SkipW-1:0]              blame_skip_i,
  output bmrrs_pkg::dec_t                          dec_o
);
  import bmrrs_pkg::*;

  logic            in_range;
  logic            open_bnd;
  logic            eligible;
  logic [ValW-1:0] mag_c;
  logic [ValW-1:0] mag_l;
  logic [ValW-1:0] mag_u;

  // Magnitudes of the coefficient and of both bounds.
  assign mag_c = mag48(item_i.coefficient);
  assign mag_l = mag48(item_i.var_lower);
  assign mag_u = mag48(item_i.var_upper);

  // A variable outside the column range counts as open but is never blamed.
  assign in_range = {1'b0, item_i.variable_index} < SkipW'(NumVariables);
  assign open_bnd = !in_range
                 || ($signed(item_i.var_upper) >= $signed({1'b0, open_limit_i}))
                 || ($signed(item_i.var_lower) <= open_neg_i);

  // A variable term on an active row with a coefficient above the threshold.
  assign eligible = !item_i.is_constant && item_i.row_active
                 && (mag_c > ValW'(coef_eps_i));

  always_comb begin
    dec_o                   = '0;
    dec_o.ctl.add_offset    = item_i.is_constant && item_i.row_active;
    dec_o.ctl.row_end       = item_i.last_in_row || item_i.last_in_constraint;
    dec_o.ctl.row_active    = item_i.row_active;
    dec_o.ctl.rhs_nonfinite = item_i.rhs_nonfinite;
    dec_o.ctl.last_c        = item_i.last_in_constraint;
    dec_o.ctl.set_unb       = eligible && open_bnd;
    dec_o.ctl.blame_cand    = !item_i.is_constant && in_range && open_bnd
                           && ({1'b0, item_i.variable_index} != blame_skip_i);
    dec_o.ctl.idx           = item_i.variable_index;
    dec_o.add_prod          = eligible && !open_bnd;
    dec_o.mag_coef          = mag_c;
    dec_o.mag_bound         = (mag_l > mag_u) ? mag_l : mag_u;
  end

endmodule

`default_nettype wire
